// File: rtl/utf8ve_pkg.sv
// Package for the UTF-8 validate/escape core: item structs, status codes,
// job descriptor passed from the decode front to the emit back, constants.
// No dependencies.
package utf8ve_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int LINE_BITS         = 32;
    localparam int QUEUE_AW          = 2;
    localparam int QUEUE_DEPTH       = 1 << QUEUE_AW;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_BAD_LEAD  = 3'd1;
    localparam logic [2:0] STATUS_BAD_CONT  = 3'd2;
    localparam logic [2:0] STATUS_RANGE     = 3'd3;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

    localparam logic [20:0] CP_2_MIN = 21'h00080;
    localparam logic [20:0] CP_2_MAX = 21'h007FF;
    localparam logic [20:0] CP_3_MIN = 21'h00800;
    localparam logic [20:0] CP_3_MAX = 21'h0FFFF;
    localparam logic [20:0] CP_4_MIN = 21'h10000;
    localparam logic [20:0] CP_4_MAX = 21'h10FFFF;
    localparam logic [20:0] CP_5_DIG = 21'h0FFFF;
    localparam logic [20:0] CP_6_DIG = 21'hFFFFF;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_UPPER_U   = 8'h55;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_PLUS      = 8'h2B;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } byte_item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [2:0]  status;
        logic [31:0] error_offset;
        logic [31:0] error_line;
        logic        run_last;
    } result_item_t;

    typedef enum logic [1:0] {
        JOB_CHAR = 2'd0,
        JOB_ESC  = 2'd1,
        JOB_STAT = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [3:0]  ndig;
        logic [20:0] code;
        logic [2:0]  status;
        logic [31:0] offset;
        logic [31:0] line;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

// File: rtl/utf8ve_front.sv
// Decode front: takes stream bytes, tracks sequence phase, position, line
// and error state, and turns each byte into at most one emit job.
// Depends on utf8ve_pkg.
module utf8ve_front #(
    parameter int POSITION_BITS = utf8ve_pkg::POSITION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  utf8ve_pkg::byte_item_t item,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    output logic                  push,
    output utf8ve_pkg::job_t      job
);

    typedef enum logic [6:0] {
        PH_IDLE         = 7'b0000001,
        PH_TWO_LAST     = 7'b0000010,
        PH_THREE_SECOND = 7'b0000100,
        PH_THREE_LAST   = 7'b0001000,
        PH_FOUR_SECOND  = 7'b0010000,
        PH_FOUR_THIRD   = 7'b0100000,
        PH_FOUR_LAST    = 7'b1000000
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic [14:0]                           partial_reg, partial_next;
    logic [POSITION_BITS-1:0]              pos_reg, pos_next;
    logic [utf8ve_pkg::LINE_BITS-1:0]      line_reg, line_next;
    logic                                  err_reg, err_next;
    logic                                  style_reg;

    logic [7:0]  b;
    logic        cont;
    logic [20:0] v;
    logic [2:0]  err_code;
    logic        range_bad;
    logic        four;

    always_comb
    begin
        b    = item.data_byte;
        cont = (b[7:6] == 2'b10);
        v    = {partial_reg, b[5:0]};
        four = (phase_reg == PH_FOUR_LAST);
        case (phase_reg)
            PH_TWO_LAST:   range_bad = (v < utf8ve_pkg::CP_2_MIN) || (v > utf8ve_pkg::CP_2_MAX);
            PH_THREE_LAST: range_bad = (v < utf8ve_pkg::CP_3_MIN) || (v > utf8ve_pkg::CP_3_MAX);
            PH_FOUR_LAST:  range_bad = (v < utf8ve_pkg::CP_4_MIN) || (v > utf8ve_pkg::CP_4_MAX);
            default:       range_bad = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        pos_next     = pos_reg;
        line_next    = line_reg;
        err_next     = err_reg;
        err_code     = utf8ve_pkg::STATUS_OK;
        push         = 1'b0;
        job          = '0;
        if (accept)
        begin
            if (!err_reg)
            begin
                case (phase_reg)
                    PH_TWO_LAST, PH_THREE_LAST, PH_FOUR_LAST:
                    begin
                        if (!cont)
                        begin
                            err_code = utf8ve_pkg::STATUS_BAD_CONT;
                        end
                        else if (range_bad)
                        begin
                            err_code = utf8ve_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            push     = 1'b1;
                            job.kind = utf8ve_pkg::JOB_ESC;
                            job.code = v;
                            if (style_reg)
                            begin
                                job.byte0 = utf8ve_pkg::CH_UPPER_U;
                                job.byte1 = utf8ve_pkg::CH_PLUS;
                                if (v > utf8ve_pkg::CP_6_DIG)
                                begin
                                    job.ndig = 4'd6;
                                end
                                else if (v > utf8ve_pkg::CP_5_DIG)
                                begin
                                    job.ndig = 4'd5;
                                end
                                else
                                begin
                                    job.ndig = 4'd4;
                                end
                            end
                            else
                            begin
                                job.byte0 = utf8ve_pkg::CH_BACKSLASH;
                                job.byte1 = four ? utf8ve_pkg::CH_UPPER_U
                                                 : utf8ve_pkg::CH_LOWER_U;
                                job.ndig  = four ? 4'd8 : 4'd4;
                            end
                            phase_next   = PH_IDLE;
                            partial_next = '0;
                        end
                    end
                    PH_THREE_SECOND, PH_FOUR_SECOND, PH_FOUR_THIRD:
                    begin
                        if (!cont)
                        begin
                            err_code = utf8ve_pkg::STATUS_BAD_CONT;
                        end
                        else
                        begin
                            partial_next = {partial_reg[8:0], b[5:0]};
                            case (phase_reg)
                                PH_THREE_SECOND: phase_next = PH_THREE_LAST;
                                PH_FOUR_SECOND:  phase_next = PH_FOUR_THIRD;
                                default:         phase_next = PH_FOUR_LAST;
                            endcase
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        if (b inside {[8'h00:8'h7F]})
                        begin
                            push      = 1'b1;
                            job.kind  = utf8ve_pkg::JOB_CHAR;
                            job.byte0 = b;
                            if (b == utf8ve_pkg::CH_NEWLINE)
                            begin
                                line_next = line_reg + 1'b1;
                            end
                        end
                        else if (b inside {[8'hC0:8'hDF]})
                        begin
                            partial_next = {10'd0, b[4:0]};
                            phase_next   = PH_TWO_LAST;
                        end
                        else if (b inside {[8'hE0:8'hEF]})
                        begin
                            partial_next = {11'd0, b[3:0]};
                            phase_next   = PH_THREE_SECOND;
                        end
                        else if (b inside {[8'hF0:8'hF7]})
                        begin
                            partial_next = {12'd0, b[2:0]};
                            phase_next   = PH_FOUR_SECOND;
                        end
                        else
                        begin
                            err_code = utf8ve_pkg::STATUS_BAD_LEAD;
                        end
                    end
                endcase
                if (err_code != utf8ve_pkg::STATUS_OK)
                begin
                    push       = 1'b1;
                    job        = '0;
                    job.kind   = utf8ve_pkg::JOB_STAT;
                    job.status = err_code;
                    job.offset = 32'(pos_reg);
                    job.line   = 32'(line_reg);
                    err_next   = 1'b1;
                end
                pos_next = pos_reg + POSITION_BITS'(1);
            end
            if (item.end_of_stream)
            begin
                // truncation: sequence still open at end of stream
                if (!err_next && phase_next != PH_IDLE)
                begin
                    push       = 1'b1;
                    job        = '0;
                    job.kind   = utf8ve_pkg::JOB_STAT;
                    job.status = utf8ve_pkg::STATUS_TRUNCATED;
                    job.offset = 32'(pos_next);
                    job.line   = 32'(line_next);
                end
                phase_next   = PH_IDLE;
                partial_next = '0;
                pos_next     = '0;
                line_next    = utf8ve_pkg::LINE_BITS'(1);
                err_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            partial_reg <= '0;
            pos_reg     <= '0;
            line_reg    <= utf8ve_pkg::LINE_BITS'(1);
            err_reg     <= 1'b0;
            style_reg   <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            pos_reg     <= pos_next;
            line_reg    <= line_next;
            err_reg     <= err_next;
            if (cfg_we)
            begin
                style_reg <= cfg_wdata;
            end
        end
    end

endmodule

// File: rtl/utf8ve_queue.sv
// Job queue between decode front and emit back; register storage,
// head visible without a pop. Depends on utf8ve_pkg.
module utf8ve_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utf8ve_pkg::job_t     push_job,
    input  logic                 pop,
    output utf8ve_pkg::job_t     head,
    output utf8ve_pkg::q_stat_t  stat
);

    localparam int AW = utf8ve_pkg::QUEUE_AW;

    utf8ve_pkg::job_t mem_reg [utf8ve_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    always_comb
    begin
        stat.full   = (count_reg == (AW+1)'(utf8ve_pkg::QUEUE_DEPTH));
        stat.empty  = (count_reg == '0);
        do_push     = push && !stat.full;
        do_pop      = pop && !stat.empty;
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: rtl/utf8ve_back.sv
// Emit back: expands the queue head job into result requests, one per
// cycle unless stalled, into a registered output stage. Depends on utf8ve_pkg.
module utf8ve_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  utf8ve_pkg::job_t         head,
    input  utf8ve_pkg::q_stat_t      stat,
    output logic                     pop,
    output logic                     result_valid,
    input  logic                     result_ready,
    output utf8ve_pkg::result_item_t result_data
);

    logic                     valid_reg, valid_next;
    utf8ve_pkg::result_item_t res_reg, res_next;
    logic [3:0]               idx_reg, idx_next;
    logic                     advance;
    logic                     last;
    logic [2:0]               nib_sel;
    logic [31:0]              code32;
    logic [3:0]               sel_full;

    always_comb
    begin
        advance  = !valid_reg || result_ready;
        code32   = {11'd0, head.code};
        sel_full = head.ndig + 4'd1 - idx_reg;
        nib_sel  = sel_full[2:0];
        res_next = '0;
        case (head.kind)
            utf8ve_pkg::JOB_CHAR:
            begin
                last              = 1'b1;
                res_next.out_byte = head.byte0;
            end
            utf8ve_pkg::JOB_ESC:
            begin
                last = (idx_reg == head.ndig + 4'd1);
                if (idx_reg == 4'd0)
                begin
                    res_next.out_byte = head.byte0;
                end
                else if (idx_reg == 4'd1)
                begin
                    res_next.out_byte = head.byte1;
                end
                else
                begin
                    res_next.out_byte = utf8ve_pkg::hex_char(code32[{nib_sel, 2'b00} +: 4]);
                end
            end
            default:
            begin
                last                  = 1'b1;
                res_next.status       = head.status;
                res_next.error_offset = head.offset;
                res_next.error_line   = head.line;
            end
        endcase
        res_next.run_last = last;

        pop        = 1'b0;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = !stat.empty;
            if (!stat.empty)
            begin
                if (last)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !stat.empty)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_data  = res_reg;

endmodule

// File: rtl/utf8_validate_escape_core.sv
// Top level of the UTF-8 validate/escape core: decode front, job queue,
// emit back, and checks. Depends on utf8ve_pkg, utf8ve_front,
// utf8ve_queue, utf8ve_back.
//
// Usage:
//  byte_valid/byte_ready/byte_data carry stream bytes with end_of_stream.
//  result_valid/result_ready/result_data carry output characters and
//  status requests; run_last marks the last request caused by a byte.
//  cfg_we/cfg_wdata write escape_style (0: \uXXXX/\UXXXXXXXX, 1: U+XXXX).
//  A byte is decoded in the cycle it is accepted; its first result comes
//  via the queue and output registers. Bytes are taken one per cycle while
//  the four-entry job queue has room. The emitter sends one result per
//  cycle: ASCII and status jobs give one, escapes give 6 to 10, so the
//  sustained rate is set by the emitter, one result request per cycle.
//  When the receiver stalls, the output register holds, the queue fills,
//  and byte_ready drops. Reset empties queue and output, clears the
//  decode state (line count 1) and sets escape_style to 0.
module utf8_validate_escape_core #(
    parameter int POSITION_BITS = utf8ve_pkg::POSITION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_valid,
    output logic                     byte_ready,
    input  utf8ve_pkg::byte_item_t   byte_data,
    output logic                     result_valid,
    input  logic                     result_ready,
    output utf8ve_pkg::result_item_t result_data,
    input  logic                     cfg_we,
    input  logic                     cfg_wdata
);

    utf8ve_pkg::job_t    push_job;
    utf8ve_pkg::job_t    head;
    utf8ve_pkg::q_stat_t q_stat;
    logic                push;
    logic                pop;
    logic                accept;

    assign byte_ready = !q_stat.full;
    assign accept     = byte_valid && byte_ready;

    utf8ve_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (byte_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .push     (push),
        .job      (push_job)
    );

    utf8ve_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    utf8ve_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .stat        (q_stat),
        .pop         (pop),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result_data (result_data)
    );

    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status != utf8ve_pkg::STATUS_OK
        |-> result_data.run_last && result_data.out_byte == 8'd0)
        else $error("status request not a single zero-byte request");

    a_ok_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.status == utf8ve_pkg::STATUS_OK
        |-> result_data.error_offset == 32'd0 && result_data.error_line == 32'd0)
        else $error("ok request carries position");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("job pushed into full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

endmodule

// File: tb/tb_utf8_validate_escape_core.sv
// Self-checking testbench for utf8_validate_escape_core: directed and random byte streams,
// predicted escape text and error reports compared request by request under random stalls.
// Depends on utf8ve_pkg and the core RTL.
module tb_utf8_validate_escape_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;

    typedef enum logic [2:0] {
        SEQ_IDLE     = 3'd0,
        SEQ_2_LAST   = 3'd1,
        SEQ_3_SECOND = 3'd2,
        SEQ_3_LAST   = 3'd3,
        SEQ_4_SECOND = 3'd4,
        SEQ_4_THIRD  = 3'd5,
        SEQ_4_LAST   = 3'd6
    } seq_phase_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     byte_valid = 1'b0;
    logic                     byte_ready;
    utf8ve_pkg::byte_item_t   byte_data = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    utf8ve_pkg::result_item_t result_data;
    logic                     cfg_we = 1'b0;
    logic                     cfg_wdata = 1'b0;

    // decoder shadow state
    seq_phase_t  dec_phase = SEQ_IDLE;
    logic [20:0] dec_partial = '0;
    logic [31:0] dec_position = '0;
    logic [31:0] dec_line = 32'd1;
    logic        dec_error = 1'b0;
    logic        dec_style = 1'b0;

    utf8ve_pkg::result_item_t escaped_text_q[$];
    utf8ve_pkg::result_item_t burst[0:10];
    int                       burst_len;
    logic [7:0]               stream_bytes[$];

    int   failures = 0;
    logic sender_steady = 1'b0;
    logic sink_steady = 1'b0;
    logic stall_request = 1'b0;

    utf8_validate_escape_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void add_result(logic [7:0] ch, logic [2:0] st,
                                       logic [31:0] off, logic [31:0] line);
        burst[burst_len].out_byte     = ch;
        burst[burst_len].status       = st;
        burst[burst_len].error_offset = off;
        burst[burst_len].error_line   = line;
        burst[burst_len].run_last     = 1'b0;
        burst_len++;
    endfunction

    function automatic void add_escape(logic [20:0] value, logic four_byte);
        int          digits;
        int          i;
        logic [31:0] wide;
        logic [3:0]  nib;
        wide = {11'd0, value};
        if (dec_style)
        begin
            digits = (value > utf8ve_pkg::CP_6_DIG) ? 6
                   : ((value > utf8ve_pkg::CP_5_DIG) ? 5 : 4);
            add_result(utf8ve_pkg::CH_UPPER_U, utf8ve_pkg::STATUS_OK, '0, '0);
            add_result(utf8ve_pkg::CH_PLUS, utf8ve_pkg::STATUS_OK, '0, '0);
        end
        else
        begin
            digits = four_byte ? 8 : 4;
            add_result(utf8ve_pkg::CH_BACKSLASH, utf8ve_pkg::STATUS_OK, '0, '0);
            add_result(four_byte ? utf8ve_pkg::CH_UPPER_U : utf8ve_pkg::CH_LOWER_U,
                       utf8ve_pkg::STATUS_OK, '0, '0);
        end
        for (i = digits - 1; i >= 0; i--)
        begin
            nib = wide[4*i +: 4];
            add_result((nib < 4'd10) ? ("0" + nib) : ("A" + (nib - 4'd10)),
                       utf8ve_pkg::STATUS_OK, '0, '0);
        end
    endfunction

    // Work out the requests one accepted byte causes and queue them.
    function automatic void decode_byte(logic [7:0] b, logic eos);
        logic [2:0]  err;
        logic [31:0] here;
        logic [20:0] cp;
        logic        cont;
        logic        in_range;
        int          k;
        burst_len = 0;
        if (!dec_error)
        begin
            here = dec_position;
            err  = utf8ve_pkg::STATUS_OK;
            cont = (b[7:6] == 2'b10);
            case (dec_phase)
                SEQ_2_LAST, SEQ_3_LAST, SEQ_4_LAST:
                begin
                    if (!cont)
                    begin
                        err = utf8ve_pkg::STATUS_BAD_CONT;
                    end
                    else
                    begin
                        cp = {dec_partial[14:0], b[5:0]};
                        if (dec_phase == SEQ_2_LAST)
                            in_range = (cp >= utf8ve_pkg::CP_2_MIN) && (cp <= utf8ve_pkg::CP_2_MAX);
                        else if (dec_phase == SEQ_3_LAST)
                            in_range = (cp >= utf8ve_pkg::CP_3_MIN) && (cp <= utf8ve_pkg::CP_3_MAX);
                        else
                            in_range = (cp >= utf8ve_pkg::CP_4_MIN) && (cp <= utf8ve_pkg::CP_4_MAX);
                        if (!in_range)
                        begin
                            err = utf8ve_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            add_escape(cp, dec_phase == SEQ_4_LAST);
                            dec_phase   = SEQ_IDLE;
                            dec_partial = '0;
                        end
                    end
                end
                SEQ_3_SECOND, SEQ_4_SECOND, SEQ_4_THIRD:
                begin
                    if (!cont)
                    begin
                        err = utf8ve_pkg::STATUS_BAD_CONT;
                    end
                    else
                    begin
                        dec_partial = {dec_partial[14:0], b[5:0]};
                        dec_phase   = seq_phase_t'(dec_phase + 3'd1);
                    end
                end
                default:
                begin
                    if (b[7] == 1'b0)
                    begin
                        add_result(b, utf8ve_pkg::STATUS_OK, '0, '0);
                        if (b == utf8ve_pkg::CH_NEWLINE)
                            dec_line = dec_line + 32'd1;
                        dec_phase = SEQ_IDLE;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        dec_partial = {16'd0, b[4:0]};
                        dec_phase   = SEQ_2_LAST;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        dec_partial = {17'd0, b[3:0]};
                        dec_phase   = SEQ_3_SECOND;
                    end
                    else if (b[7:3] == 5'b11110)
                    begin
                        dec_partial = {18'd0, b[2:0]};
                        dec_phase   = SEQ_4_SECOND;
                    end
                    else
                    begin
                        err = utf8ve_pkg::STATUS_BAD_LEAD;
                    end
                end
            endcase
            if (err != utf8ve_pkg::STATUS_OK)
            begin
                add_result(8'd0, err, here, dec_line);
                dec_error = 1'b1;
            end
            dec_position = dec_position + 32'd1;
        end
        if (eos)
        begin
            if (!dec_error && dec_phase != SEQ_IDLE)
                add_result(8'd0, utf8ve_pkg::STATUS_TRUNCATED, dec_position, dec_line);
            dec_phase    = SEQ_IDLE;
            dec_partial  = '0;
            dec_position = '0;
            dec_line     = 32'd1;
            dec_error    = 1'b0;
        end
        if (burst_len > 0)
            burst[burst_len-1].run_last = 1'b1;
        for (k = 0; k < burst_len; k++)
            escaped_text_q.push_back(burst[k]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        utf8ve_pkg::result_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (escaped_text_q.size() == 0)
            begin
                $error("result request with none expected: out_byte %0h status %0d",
                       result_data.out_byte, result_data.status);
                failures++;
            end
            else
            begin
                want = escaped_text_q.pop_front();
                check_field("out_byte", 32'(want.out_byte), 32'(result_data.out_byte));
                check_field("status", 32'(want.status), 32'(result_data.status));
                check_field("error_offset", want.error_offset, result_data.error_offset);
                check_field("error_line", want.error_line, result_data.error_line);
                check_field("run_last", 32'(want.run_last), 32'(result_data.run_last));
            end
        end
    end

    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ready <= sink_steady || ($urandom_range(99) >= 22);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        if (!sender_steady && $urandom_range(99) < 28)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_data  <= '{data_byte: b, end_of_stream: eos};
        byte_valid <= 1'b1;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        decode_byte(b, eos);
    endtask

    task automatic send_stream();
        int i;
        for (i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
        stream_bytes.delete();
    endtask

    task automatic drain_results();
        byte_valid <= 1'b0;
        while (escaped_text_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_escape_style(input logic style);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= style;
        @(posedge clk);
        cfg_we    <= 1'b0;
        dec_style = style;
    endtask

    function automatic void append_code_point(logic [20:0] cp, int len);
        case (len)
            1: stream_bytes.push_back({1'b0, cp[6:0]});
            2:
            begin
                stream_bytes.push_back({3'b110, cp[10:6]});
                stream_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                stream_bytes.push_back({4'b1110, cp[15:12]});
                stream_bytes.push_back({2'b10, cp[11:6]});
                stream_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                stream_bytes.push_back({5'b11110, cp[20:18]});
                stream_bytes.push_back({2'b10, cp[17:12]});
                stream_bytes.push_back({2'b10, cp[11:6]});
                stream_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Mostly well-formed code points, some overlong/out-of-range, noise and cut sequences.
    function automatic void build_random_stream();
        int          units;
        int          kind;
        int          len;
        int          cut;
        logic [20:0] cp;
        units = $urandom_range(1, 8);
        repeat (units)
        begin
            kind = $urandom_range(99);
            len  = $urandom_range(2, 4);
            if (kind < 30)
            begin
                cp = ($urandom_range(3) == 0) ? {13'd0, utf8ve_pkg::CH_NEWLINE}
                                              : 21'($urandom_range(127));
                append_code_point(cp, 1);
            end
            else if (kind < 75)
            begin
                if (len == 2)
                    cp = 21'($urandom_range(utf8ve_pkg::CP_2_MIN, utf8ve_pkg::CP_2_MAX));
                else if (len == 3)
                    cp = 21'($urandom_range(utf8ve_pkg::CP_3_MIN, utf8ve_pkg::CP_3_MAX));
                else
                    cp = 21'($urandom_range(utf8ve_pkg::CP_4_MIN, utf8ve_pkg::CP_4_MAX));
                append_code_point(cp, len);
            end
            else if (kind < 85)
            begin
                cp = 21'($urandom_range(21'h1FFFFF));
                append_code_point(cp, len);
            end
            else if (kind < 93)
            begin
                stream_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                append_code_point(21'($urandom_range(21'h1FFFFF)), len);
                if ($urandom_range(1) == 0)
                begin
                    cut = $urandom_range(1, len - 1);
                    repeat (cut) void'(stream_bytes.pop_back());
                end
                else
                begin
                    stream_bytes[stream_bytes.size()-1] = 8'($urandom_range(255));
                end
            end
        end
    endfunction

    task automatic test_ascii_and_limits();
        write_escape_style(1'b0);
        stream_bytes = {8'h00, 8'h7F, 8'h0A, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_stream();
    endtask

    task automatic test_error_reporting();
        stream_bytes = {8'hFF, 8'h41};          // bad lead, then silent
        send_stream();
        stream_bytes = {8'h80};                 // stray continuation as lead
        send_stream();
        stream_bytes = {8'hE0, 8'h41};          // bad continuation on second byte
        send_stream();
        stream_bytes = {8'h0A, 8'hC0, 8'h80};   // overlong on line 2
        send_stream();
        stream_bytes = {8'hE2, 8'h82};          // truncated at end
        send_stream();
    endtask

    task automatic test_uplus_style();
        write_escape_style(1'b1);
        stream_bytes = {8'hEF, 8'hBF, 8'hBF};
        send_stream();
        stream_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_stream();
    endtask

    // Receiver holds off while the sender keeps offering; queue fills and input stalls.
    task automatic test_backpressure();
        drain_results();
        stall_request = 1'b1;
        sender_steady = 1'b1;
        repeat (12)
            append_code_point(21'($urandom_range(utf8ve_pkg::CP_2_MIN, utf8ve_pkg::CP_2_MAX)), 2);
        send_stream();
        sender_steady = 1'b0;
        drain_results();
    endtask

    task automatic test_full_rate();
        sender_steady = 1'b1;
        sink_steady   = 1'b1;
        repeat (6)
        begin
            build_random_stream();
            send_stream();
        end
        sender_steady = 1'b0;
        sink_steady   = 1'b0;
    endtask

    task automatic test_random_streams(input int target);
        int sent;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(5) == 0)
                write_escape_style(1'($urandom_range(1)));
            build_random_stream();
            sent += stream_bytes.size();
            send_stream();
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_ascii_and_limits();
        test_error_reporting();
        test_uplus_style();
        test_backpressure();
        test_full_rate();
        test_random_streams(150);
        drain_results();
        if (failures == 0)
            $display("utf8_validate_escape_core regression: pass");
        else
            $display("utf8_validate_escape_core regression: fail");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("utf8_validate_escape_core regression: fail");
        $finish;
    end

endmodule

// File: filelist.f
rtl/utf8ve_pkg.sv
rtl/utf8ve_front.sv
rtl/utf8ve_queue.sv
rtl/utf8ve_back.sv
rtl/utf8_validate_escape_core.sv
tb/tb_utf8_validate_escape_core.sv
